// ===== hw/rtl/pfde_pkg.sv =====
// shared types and constants for the sound frame delta encoder
`default_nettype none

package pfde_pkg;

    localparam int NUM_CH    = 3;
    localparam int PER_W     = 12;
    localparam int ATT_W     = 4;
    localparam int VOL_W     = 5;
    localparam int WORD_W    = 16;
    localparam int CNT_W     = 12;
    localparam int NUM_SLOTS = NUM_CH + 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = 12'd4095;
    // stored volume value meaning no volume seen yet
    localparam logic [VOL_W-1:0] VOL_NONE  = 5'd16;

    // attenuation to volume table
    localparam logic [3:0] VOL_MAP [16] = '{
        4'd15, 4'd14, 4'd14, 4'd13, 4'd12, 4'd12, 4'd11, 4'd10,
        4'd10, 4'd9,  4'd8,  4'd8,  4'd7,  4'd6,  4'd6,  4'd0
    };

    typedef enum logic [1:0] {
        KIND_HDR  = 2'd0,
        KIND_CHAN = 2'd1,
        KIND_TERM = 2'd2
    } t_kind;

    // per-lane detection result
    typedef struct packed {
        logic                changed;
        logic [WORD_W-1:0]   word;
    } t_lane_res;

    // one burst of output words: slot 0 header, slots 1..3 channels, slot 4 terminator
    typedef struct packed {
        logic [NUM_SLOTS-1:0]           sel;
        logic [WORD_W-1:0]              hdr;
        logic [NUM_CH-1:0][WORD_W-1:0]  words;
    } t_burst;

endpackage

`default_nettype wire

// ===== hw/rtl/pfde_if.sv =====
// request channel interfaces for frames in and words out
`default_nettype none

interface pfde_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [11:0] period_a;
    logic [3:0]  atten_a;
    logic [11:0] period_b;
    logic [3:0]  atten_b;
    logic [11:0] period_c;
    logic [3:0]  atten_c;

    modport source (
        output valid, op, period_a, atten_a, period_b, atten_b, period_c, atten_c,
        input  ready
    );
    modport sink (
        input  valid, op, period_a, atten_a, period_b, atten_b, period_c, atten_c,
        output ready
    );
endinterface

interface pfde_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] word;
    logic [1:0]  kind;
    logic        last;

    modport source (
        output valid, word, kind, last,
        input  ready
    );
    modport sink (
        input  valid, word, kind, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/pfde_lane.sv =====
// one channel lane: stored volume and period, change detection
`default_nettype none

module pfde_lane (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [pfde_pkg::PER_W-1:0]   i_period,
    input  wire logic [pfde_pkg::ATT_W-1:0]   i_atten,
    input  wire logic                         i_enable,
    input  wire logic                         i_take,
    input  wire logic                         i_clear,
    output pfde_pkg::t_lane_res               o_res
);
    import pfde_pkg::*;

    logic [VOL_W-1:0] r_last_vol;
    logic [PER_W-1:0] r_last_per;
    logic [3:0]       vol;
    logic             changed;

    // mapped volume and change test
    always_comb begin
        vol     = VOL_MAP[i_atten];
        changed = i_enable &&
                  ((r_last_vol != {1'b0, vol}) ||
                   ((r_last_per != i_period) && (r_last_vol != '0)));
        o_res.changed = changed;
        o_res.word    = {i_period, vol};
    end

    // stored channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_last_vol <= VOL_NONE;
            r_last_per <= '0;
        end else if (i_take && changed) begin
            r_last_vol <= {1'b0, vol};
            r_last_per <= i_period;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pfde_merge.sv =====
// merge stage: combines lane results, holds the pending record, forms bursts
`default_nettype none

module pfde_merge (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire pfde_pkg::t_lane_res [pfde_pkg::NUM_CH-1:0] i_lanes,
    input  wire logic                                i_frame_acc,
    input  wire logic                                i_end_acc,
    output pfde_pkg::t_burst                         o_burst,
    output logic                                     o_push
);
    import pfde_pkg::*;

    logic [NUM_CH-1:0]             r_held_mask;
    logic [CNT_W-1:0]              r_count;
    logic                          r_held;
    logic [NUM_CH-1:0][WORD_W-1:0] r_words;
    logic [NUM_CH-1:0]             mask;

    // change mask over lanes
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            mask[i] = i_lanes[i].changed;
        end
    end

    // burst of the held record, plus terminator on end
    always_comb begin
        o_burst.hdr   = {r_count, 1'b0, r_held_mask};
        o_burst.words = r_words;
        o_burst.sel   = '0;
        if (i_end_acc) begin
            o_burst.sel = {1'b1, r_held_mask, r_held};
        end else if (i_frame_acc && (mask != '0)) begin
            o_burst.sel = {1'b0, r_held_mask, r_held};
        end
        o_push = (o_burst.sel != '0);
    end

    // held record control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_end_acc) begin
            r_held_mask <= '0;
            r_count     <= '0;
            r_held      <= 1'b0;
        end else if (i_frame_acc) begin
            if (mask != '0) begin
                r_held_mask <= mask;
                r_count     <= CNT_W'(1);
                r_held      <= 1'b1;
            end else if (r_count < COUNT_MAX) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // held channel words
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_CH; i++) begin
            if (i_frame_acc && !i_end_acc && mask[i]) begin
                r_words[i] <= i_lanes[i].word;
            end
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_end_acc |=> (!r_held && (r_count == '0) && (r_held_mask == '0)))
        else $error("end request did not clear held record");

    a_held_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> ((r_count != '0) && (r_held_mask != '0)))
        else $error("held record with zero count or empty mask");

endmodule

`default_nettype wire

// ===== hw/rtl/pfde_serializer.sv =====
// two-deep burst queue and word serializer onto the result channel
`default_nettype none

module pfde_serializer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pfde_pkg::t_burst i_burst,
    input  wire logic            i_push,
    output logic                 o_ready,
    pfde_out_if.source           o_result
);
    import pfde_pkg::*;

    t_burst               r_act;
    t_burst               r_pend;
    logic [NUM_SLOTS-1:0] cur;
    logic [NUM_SLOTS-1:0] rest;
    logic [NUM_SLOTS-1:0] act_after;
    logic                 out_acc;

    // room while the second burst slot is free
    assign o_ready = (r_pend.sel == '0);

    // current slot is the lowest set bit
    always_comb begin
        cur  = r_act.sel & (~r_act.sel + NUM_SLOTS'(1));
        rest = r_act.sel & ~cur;
        o_result.valid = (r_act.sel != '0);
        o_result.last  = (rest == '0);
        o_result.word  = '0;
        o_result.kind  = KIND_TERM;
        case (cur)
            5'b00001: begin
                o_result.word = r_act.hdr;
                o_result.kind = KIND_HDR;
            end
            5'b00010: begin
                o_result.word = r_act.words[0];
                o_result.kind = KIND_CHAN;
            end
            5'b00100: begin
                o_result.word = r_act.words[1];
                o_result.kind = KIND_CHAN;
            end
            5'b01000: begin
                o_result.word = r_act.words[2];
                o_result.kind = KIND_CHAN;
            end
            default: begin
                o_result.word = '0;
                o_result.kind = KIND_TERM;
            end
        endcase
        out_acc   = o_result.valid && o_result.ready;
        act_after = out_acc ? rest : r_act.sel;
    end

    // burst slot advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act.sel  <= '0;
            r_pend.sel <= '0;
        end else if (act_after == '0) begin
            if (r_pend.sel != '0) begin
                r_act      <= r_pend;
                r_pend.sel <= '0;
            end else if (i_push) begin
                r_act <= i_burst;
            end else begin
                r_act.sel <= '0;
            end
        end else begin
            r_act.sel <= act_after;
            if (i_push) begin
                r_pend <= i_burst;
            end
        end
    end

    a_pend_behind_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend.sel != '0) |-> (r_act.sel != '0))
        else $error("queued burst while serializer is empty");

    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.kind == KIND_TERM)) |-> o_result.last)
        else $error("terminator not flagged as final word");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("burst pushed with no free slot");

endmodule

`default_nettype wire

// ===== hw/rtl/psg_frame_delta_encoder_unit.sv =====
// top level of the sound frame delta encoder
//
//  channel    dir  handshake        payload
//  i_frame    in   valid/ready      op, period_a/b/c, atten_a/b/c
//  o_result   out  valid/ready      word, kind, last
//  apb        in   psel/penable     channel_disable at address 0
//
// a request is taken on valid and ready; the three lanes and merge stage update at once
// each request yields 0 to 5 words, sent from a two-burst queue one per cycle
// while o_result.ready is high, so the sustained rate is set by the result channel;
// requests that yield no words are accepted while a burst slot is free
// i_frame.ready drops only while both burst slots are occupied
// reset is synchronous, active low, and clears all control state
`default_nettype none

module psg_frame_delta_encoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pfde_in_if.sink          i_frame,
    pfde_out_if.source       o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pfde_pkg::*;

    logic [NUM_CH-1:0]             r_disable;
    logic [NUM_CH-1:0][PER_W-1:0]  periods;
    logic [NUM_CH-1:0][ATT_W-1:0]  attens;
    t_lane_res [NUM_CH-1:0]        lanes;
    t_burst                        burst;
    logic                          push;
    logic                          ser_ready;
    logic                          acc;
    logic                          frame_acc;
    logic                          end_acc;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {29'd0, r_disable} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disable <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_disable <= pwdata[NUM_CH-1:0];
        end
    end

    // request accept
    assign i_frame.ready = ser_ready;
    assign acc       = i_frame.valid && ser_ready;
    assign frame_acc = acc && !i_frame.op;
    assign end_acc   = acc && i_frame.op;

    assign periods = {i_frame.period_c, i_frame.period_b, i_frame.period_a};
    assign attens  = {i_frame.atten_c, i_frame.atten_b, i_frame.atten_a};

    // channel lanes
    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        pfde_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_period (periods[g]),
            .i_atten  (attens[g]),
            .i_enable (!r_disable[g]),
            .i_take   (frame_acc),
            .i_clear  (end_acc),
            .o_res    (lanes[g])
        );
    end

    // merge stage
    pfde_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lanes     (lanes),
        .i_frame_acc (frame_acc),
        .i_end_acc   (end_acc),
        .o_burst     (burst),
        .o_push      (push)
    );

    // word serializer
    pfde_serializer u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_burst  (burst),
        .i_push   (push),
        .o_ready  (ser_ready),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
